### src/cfrx_pkg.sv
// ----------------------------------------------------------------------------
// cfrx_pkg: shared types and helpers of the CRC-checked frame receiver
// Status codes, the command passed from the parser to the readout side, the
// payload store write port, the configuration bundle and the CRC step.
// ----------------------------------------------------------------------------
package cfrx_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 64;
   localparam int LEN_W               = 7;

   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic [7:0]       sync_first;
      logic [7:0]       sync_second;
      logic [LEN_W-1:0] max_length;
   } cfg_type;

   // One command per accepted byte: either a single status beat or a
   // readout of a completed frame from the payload store.
   typedef struct packed {
      logic             readout;
      logic [1:0]       status;
      logic [LEN_W-1:0] length;
   } cmd_type;

   typedef struct packed {
      logic             we;
      logic [LEN_W-1:0] addr;
      logic [7:0]       data;
   } wr_type;

   // CRC-16, polynomial 0x1021, MSB first, one byte per call.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### src/crc_checked_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_top: length-prefixed frame receiver with CRC-16
// Configuration registers, byte parser, command queue and result side.
// ----------------------------------------------------------------------------
// Every accepted byte produces one status beat (in progress or rejected),
// except the byte that completes a frame with a good CRC-16/CCITT-FALSE
// check, which produces one beat per stored payload byte with tlast on the
// final one. The parser takes one byte per cycle while the two-entry command
// queue has room; the result side takes a status command once the output
// register is free and loads its beat there, and for a completed frame it
// takes the command, then does one store read and one output load per byte,
// holding each load while the output is stalled. While a readout runs the
// parser stalls once the queue holds two commands. Configuration writes are
// accepted in every cycle.
module crc_checked_frame_receiver_top
   import cfrx_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [14:8] frame_length, [15] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH  = 2'd2;

   cfg_type cfg_ff, cfg_in;
   cmd_type push_data, pop_data;
   wr_type  wr;
   logic    cmd_full, cmd_empty, cmd_push, cmd_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_data;
            CSR_SYNC_SECOND: cfg_in.sync_second = csr_data;
            CSR_MAX_LENGTH:  cfg_in.max_length  = csr_data[LEN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sync_first: 8'hAA, sync_second: 8'h55, max_length: 7'd64};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfrx_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd_data   (push_data),
      .wr         (wr)
   );

   cfrx_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (pop_data)
   );

   cfrx_back #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .cmd_empty  (cmd_empty),
      .cmd_data   (pop_data),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### src/cfrx_front.sv
// ----------------------------------------------------------------------------
// cfrx_front: byte parser of the frame receiver
// Hunts for the sync pair, reads length, payload and check bytes, keeps the
// running CRC, writes payload bytes to the store and issues one command per
// accepted byte.
// ----------------------------------------------------------------------------
module cfrx_front
   import cfrx_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       cmd_full,
   output logic       cmd_push,
   output cmd_type    cmd_data,
   output wr_type     wr
);

   localparam logic [2:0] PH_SYNC1  = 3'd0;
   localparam logic [2:0] PH_SYNC2  = 3'd1;
   localparam logic [2:0] PH_LEN_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_CRC_LO = 3'd5;
   localparam logic [2:0] PH_CRC_HI = 3'd6;

   localparam int LIMIT_CAP = (MAX_PAYLOAD < 127) ? MAX_PAYLOAD : 127;

   logic [2:0]       phase_ff, phase_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] position_ff, position_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       check_lo_ff, check_lo_in;

   logic             accept;
   logic [7:0]       b;
   logic [15:0]      crc_step;
   logic [15:0]      len_full;
   logic [LEN_W-1:0] limit;
   logic [LEN_W-1:0] pos_next;

   assign req_tready = !cmd_full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign len_full   = {b, len_lo_ff};
   assign pos_next   = position_ff + 1'b1;

   always_comb begin
      if (cfg.max_length > LEN_W'(LIMIT_CAP)) begin
         limit = LEN_W'(LIMIT_CAP);
      end else begin
         limit = cfg.max_length;
      end
   end

   // The low length byte restarts the CRC.
   assign crc_step = crc_byte((phase_ff == PH_LEN_LO) ? CRC_INIT : crc_ff, b);

   always_comb begin
      phase_in    = phase_ff;
      len_lo_in   = len_lo_ff;
      length_in   = length_ff;
      position_in = position_ff;
      crc_in      = crc_ff;
      check_lo_in = check_lo_ff;
      cmd_data    = '{readout: 1'b0, status: ST_BUSY, length: '0};
      wr          = '{we: 1'b0, addr: position_ff, data: b};
      case (phase_ff)
         PH_SYNC1: begin
            if (b == cfg.sync_first) begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (b == cfg.sync_second) begin
               phase_in = PH_LEN_LO;
            end else if (b != cfg.sync_first) begin
               phase_in = PH_SYNC1;
            end
         end
         PH_LEN_LO: begin
            len_lo_in = b;
            crc_in    = crc_step;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            crc_in = crc_step;
            if (len_full == 16'd0 || len_full > {9'd0, limit}) begin
               phase_in        = PH_SYNC1;
               cmd_data.status = ST_FAIL;
            end else begin
               length_in   = len_full[LEN_W-1:0];
               position_in = '0;
               phase_in    = PH_DATA;
            end
         end
         PH_DATA: begin
            wr.we       = accept;
            position_in = pos_next;
            crc_in      = crc_step;
            if (pos_next >= length_ff) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            check_lo_in = b;
            phase_in    = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            phase_in = PH_SYNC1;
            if ({b, check_lo_ff} != crc_ff) begin
               cmd_data.status = ST_FAIL;
            end else begin
               cmd_data = '{readout: 1'b1, status: ST_DONE, length: length_ff};
            end
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   assign cmd_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         len_lo_ff   <= len_lo_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         crc_ff      <= crc_in;
         check_lo_ff <= check_lo_in;
      end
   end

endmodule

### src/cfrx_cmd_fifo.sv
// ----------------------------------------------------------------------------
// cfrx_cmd_fifo: two-entry command queue
// Decouples the byte parser from the readout side so either can stall.
// ----------------------------------------------------------------------------
module cfrx_cmd_fifo
   import cfrx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type pop_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/cfrx_back.sv
// ----------------------------------------------------------------------------
// cfrx_back: result side of the frame receiver
// Holds the payload store, turns commands into result beats and reads out a
// completed frame into the output register with one store read per byte.
// ----------------------------------------------------------------------------
module cfrx_back
   import cfrx_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  wr_type      wr,
   input  logic        cmd_empty,
   input  cmd_type     cmd_data,
   output logic        cmd_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   localparam logic [1:0] BK_IDLE  = 2'd0;
   localparam logic [1:0] BK_FETCH = 2'd1;
   localparam logic [1:0] BK_EMIT  = 2'd2;

   logic [7:0]       payload_mem_ff [MAX_PAYLOAD];
   logic [7:0]       rd_data_ff;

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] n_ff, n_in;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_status_ff, out_status_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic             out_last_ff, out_last_in;

   logic             out_free;
   logic             load;
   logic             is_last;

   assign out_free = !out_valid_ff || rsp_tready;
   assign is_last  = ({1'b0, k_ff} + 8'd1) == {1'b0, n_ff};

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      cmd_pop       = 1'b0;
      load          = 1'b0;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && out_free) begin
               cmd_pop = 1'b1;
               if (cmd_data.readout) begin
                  k_in     = '0;
                  n_in     = cmd_data.length;
                  state_in = BK_FETCH;
               end else begin
                  load          = 1'b1;
                  out_status_in = cmd_data.status;
                  out_byte_in   = 8'd0;
                  out_len_in    = '0;
                  out_last_in   = 1'b1;
               end
            end
         end
         BK_FETCH: begin
            // The store read for entry k lands in rd_data_ff next cycle.
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               load          = 1'b1;
               out_status_in = ST_DONE;
               out_byte_in   = rd_data_ff;
               out_len_in    = n_ff;
               out_last_in   = is_last;
               if (is_last) begin
                  state_in = BK_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = BK_FETCH;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      n_ff          <= n_in;
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_len_ff    <= out_len_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         payload_mem_ff[AW'(wr.addr)] <= wr.data;
      end
      rd_data_ff <= payload_mem_ff[AW'(k_ff)];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_len_ff, out_byte_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
